[rtl/core/hilp_pkg.sv]
`default_nettype none

package hilp_pkg;

   // Defaults for the top-level parameters.
   localparam int ADDR_BITS_DEF         = 32;
   localparam int PROGRESS_INTERVAL_DEF = 1024;

   // Base address used after reset until the first write of the start register or the first address record.
   localparam logic [31:0] START_RESET = 32'h0001_0000;

   localparam int CHAR_W     = 8;
   localparam int EVENT_W    = 3;
   localparam int RSP_DATA_W = 128;

   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;

   localparam logic [1:0] ECHO_NONE = 2'd0;
   localparam logic [1:0] ECHO_ONE  = 2'd1;
   localparam logic [1:0] ECHO_TWO  = 2'd2;

   typedef enum logic [2:0] {
      EV_NOTHING    = 3'd0,
      EV_WRITE      = 3'd1,
      EV_ADDR_START = 3'd2,
      EV_ADDR_SET   = 3'd3,
      EV_REJECT     = 3'd4,
      EV_RUN        = 3'd5,
      EV_IGNORED    = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_HELD   = 2'd1,
      MODE_ADDR   = 2'd2
   } mode_type;

   // Bit 4 set means the character is not a hex digit; otherwise bits 3:0 hold its value.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, 4'(c - 8'h37)};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

[rtl/core/hilp_skid.sv]
`default_nettype none

module hilp_skid import hilp_pkg::*; #(
   parameter int WIDTH = EVENT_W + RSP_DATA_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] main_data_ff, main_data_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (!skid_valid_ff) begin
         if (!main_valid_ff || out_ready) begin
            main_valid_in = in_valid;
            main_data_in  = in_data;
         end else if (in_valid) begin
            // Output is stalled: park the new item in the spare stage.
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (out_ready) begin
         main_data_in  = skid_data_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTH
   a_skid_implies_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("spare stage holds an item while the output stage is empty");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      main_valid_ff && !out_ready |=> main_valid_ff && $stable(main_data_ff))
      else $error("stalled output item changed");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !out_ready |=> skid_valid_ff && $stable(skid_data_ff))
      else $error("spare stage lost its item during a stall");
`endif

endmodule

`default_nettype wire

[rtl/core/hex_image_loader_parser_unit.sv]
// Each result item is registered in the output buffer when its character item is accepted.
// Throughput: one character item per cycle; a two-stage output buffer keeps req_tready high
// for one more item while a result stalls, so a longer stall of rsp then blocks req.
// Reset (synchronous, active high) clears parse state, count and the output buffer and
// loads the start address 0x10000 as base; a csr write loads a new base and clears the count.
`default_nettype none

module hex_image_loader_parser_unit import hilp_pkg::*; #(
   parameter int ADDR_BITS         = ADDR_BITS_DEF,
   parameter int PROGRESS_INTERVAL = PROGRESS_INTERVAL_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // csr: start_address
   input  wire logic                  csr_wen,
   input  wire logic [31:0]           csr_wdata,
   // req_tdata: char_code[7:0]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [CHAR_W-1:0]     req_tdata,
   // rsp_tuser: event_res[2:0]
   // rsp_tdata: write_addr[31:0], write_data[39:32], progress_mark[40], echo_count[42:41],
   //            echo_first[50:43], echo_second[58:51], report_valid[59],
   //            report_count[91:60], report_base[123:92], zero[127:124]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [EVENT_W-1:0]         rsp_tuser,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int PHASE_W = (PROGRESS_INTERVAL > 1) ? $clog2(PROGRESS_INTERVAL) : 1;
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PROGRESS_INTERVAL - 1);

   mode_type             mode_ff, mode_in;
   logic [7:0]           held_char_ff, held_char_in;
   logic [ADDR_BITS-1:0] base_ff, base_in;
   logic [31:0]          count_ff, count_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [ADDR_BITS-1:0] acc_ff, acc_in;
   logic                 finished_ff, finished_in;

   logic                 accept;
   logic [4:0]           hex_in;
   logic [4:0]           hex_held;
   logic                 is_hex;
   logic                 is_space;
   logic [63:0]          sum_wide;
   logic [63:0]          addr64;
   logic [63:0]          base64;

   event_type            r_event;
   logic [31:0]          r_write_addr;
   logic [7:0]           r_write_data;
   logic                 r_progress;
   logic [1:0]           r_echo_count;
   logic [7:0]           r_echo_first;
   logic [7:0]           r_echo_second;
   logic                 r_report_valid;
   logic [31:0]          r_report_count;
   logic [31:0]          r_report_base;
   logic [RSP_DATA_W-1:0] r_data;

   assign accept   = req_tvalid && req_tready;
   assign hex_in   = hex_value(req_tdata);
   assign hex_held = hex_value(held_char_ff);
   assign is_hex   = !hex_in[4];
   assign is_space = (req_tdata == CHAR_SPACE) || (req_tdata == CHAR_TAB) ||
                     (req_tdata == CHAR_CR) || (req_tdata == CHAR_LF);
   assign sum_wide = 64'(base_ff) + 64'(count_ff);
   assign addr64   = 64'(sum_wide[ADDR_BITS-1:0]);
   assign base64   = 64'(base_ff);

   // Next state.
   always_comb begin
      mode_in      = mode_ff;
      held_char_in = held_char_ff;
      base_in      = base_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      finished_in  = finished_ff;
      if (csr_wen) begin
         base_in  = ADDR_BITS'(csr_wdata);
         count_in = '0;
         phase_in = '0;
      end else if (accept && !finished_ff) begin
         case (mode_ff)
            MODE_ADDR: begin
               if (is_hex) begin
                  acc_in = {acc_ff[ADDR_BITS-5:0], hex_in[3:0]};
               end else begin
                  base_in  = acc_ff;
                  count_in = '0;
                  phase_in = '0;
                  mode_in  = MODE_NORMAL;
               end
            end
            MODE_HELD: begin
               mode_in = MODE_NORMAL;
               if (is_hex) begin
                  count_in = count_ff + 32'd1;
                  // The phase restarts where the count wraps, so it always equals
                  // the count modulo the progress interval.
                  if (phase_ff == PHASE_LAST || count_ff == '1) begin
                     phase_in = '0;
                  end else begin
                     phase_in = phase_ff + PHASE_W'(1);
                  end
               end
            end
            default: begin
               if (req_tdata == CHAR_END) begin
                  finished_in = 1'b1;
               end else if (req_tdata == CHAR_AT) begin
                  acc_in  = '0;
                  mode_in = MODE_ADDR;
               end else if (is_hex) begin
                  held_char_in = req_tdata;
                  mode_in      = MODE_HELD;
               end
            end
         endcase
      end
   end

   // Result item for the character at the input.
   always_comb begin
      r_event        = EV_NOTHING;
      r_write_addr   = '0;
      r_write_data   = '0;
      r_progress     = 1'b0;
      r_echo_count   = ECHO_NONE;
      r_echo_first   = '0;
      r_echo_second  = '0;
      r_report_valid = 1'b0;
      r_report_count = '0;
      r_report_base  = '0;
      if (finished_ff) begin
         r_event = EV_IGNORED;
      end else begin
         case (mode_ff)
            MODE_ADDR: begin
               if (!is_hex) begin
                  r_event = EV_ADDR_SET;
               end
            end
            MODE_HELD: begin
               if (is_hex) begin
                  r_event      = EV_WRITE;
                  r_write_addr = addr64[31:0];
                  r_write_data = {hex_held[3:0], hex_in[3:0]};
                  r_progress   = (phase_ff == '0);
               end else begin
                  r_event       = EV_REJECT;
                  r_echo_count  = ECHO_TWO;
                  r_echo_first  = held_char_ff;
                  r_echo_second = req_tdata;
               end
            end
            default: begin
               if (req_tdata == CHAR_END || req_tdata == CHAR_AT) begin
                  r_event = (req_tdata == CHAR_END) ? EV_RUN : EV_ADDR_START;
                  if (count_ff != '0) begin
                     r_report_valid = 1'b1;
                     r_report_count = count_ff;
                     r_report_base  = base64[31:0];
                  end
               end else if (!is_hex && !is_space) begin
                  r_event      = EV_REJECT;
                  r_echo_count = ECHO_ONE;
                  r_echo_first = req_tdata;
               end
            end
         endcase
      end
   end

   assign r_data = {4'b0000, r_report_base, r_report_count, r_report_valid, r_echo_second,
                    r_echo_first, r_echo_count, r_progress, r_write_data, r_write_addr};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         held_char_ff <= '0;
         base_ff      <= ADDR_BITS'(START_RESET);
         count_ff     <= '0;
         phase_ff     <= '0;
         acc_ff       <= '0;
         finished_ff  <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         held_char_ff <= held_char_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         finished_ff  <= finished_in;
      end
   end

   hilp_skid #(
      .WIDTH (EVENT_W + RSP_DATA_W)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   ({r_event, r_data}),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  ({rsp_tuser, rsp_tdata})
   );

`ifndef SYNTH
   a_finished_sticks: assert property (@(posedge clock) disable iff (reset)
      finished_ff && !csr_wen |=> finished_ff)
      else $error("end of load was cleared");
   a_ignored_after_end: assert property (@(posedge clock) disable iff (reset)
      accept && finished_ff |-> r_event == EV_IGNORED)
      else $error("character after end produced an event other than ignored");
   a_mode_normal_when_done: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> mode_ff == MODE_NORMAL)
      else $error("parser left a record open at end of load");
   a_ready_only_stalls: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input blocked with no result pending");
`endif

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import hilp_pkg::*;

   localparam int RSP_HOLD_CYCLES = 400;

   typedef struct packed {
      event_type   ev;
      logic [31:0] write_addr;
      logic [7:0]  write_data;
      logic        progress;
      logic [1:0]  echo_n;
      logic [7:0]  echo_a;
      logic [7:0]  echo_b;
      logic        rpt_valid;
      logic [31:0] rpt_count;
      logic [31:0] rpt_base;
   } load_event_type;

   typedef struct {
      logic [7:0]     ch;
      bit             typed;
      load_event_type want;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wen = 1'b0;
   logic [31:0]           csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_W-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [EVENT_W-1:0]    rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Parser state as the loader should hold it.
   logic [31:0] cur_base;
   logic [31:0] cur_count;
   logic [31:0] addr_acc;
   mode_type    cur_mode;
   logic [3:0]  held_val;
   logic [7:0]  held_ch;
   bit          load_done;

   load_event_type pending_events[$];
   load_event_type head;
   dir_row_type    dir_rows [26];

   int  mismatches = 0;
   int  chars_sent = 0;
   int  settings = 0;
   int  results_seen = 0;
   int  marks_seen = 0;
   int  ev_seen [8];
   bit  tx_calm = 1'b0;
   bit  rx_calm = 1'b0;
   bit  hold_rsp = 1'b0;

   hex_image_loader_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("simulation failed");
      $finish;
   end

   // Returns the digit value with bit 4 clear, or bit 4 set for anything else.
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c inside {["0":"9"]}) return {1'b0, 4'(c)};
      if (c inside {["a":"f"], ["A":"F"]}) return {1'b0, 4'(c[3:0] + 4'd9)};
      return 5'h10;
   endfunction

   function automatic load_event_type parse_char(input logic [7:0] c);
      load_event_type r;
      logic [4:0]     nib;
      r = '0;
      nib = nibble_of(c);
      if (load_done) begin
         r.ev = EV_IGNORED;
      end else if (cur_mode == MODE_ADDR) begin
         if (!nib[4]) begin
            addr_acc = {addr_acc[27:0], nib[3:0]};
         end else begin
            // The terminator itself is dropped, whatever it is.
            cur_base = addr_acc;
            cur_count = '0;
            cur_mode = MODE_NORMAL;
            r.ev = EV_ADDR_SET;
         end
      end else if (cur_mode == MODE_HELD) begin
         cur_mode = MODE_NORMAL;
         if (!nib[4]) begin
            r.ev = EV_WRITE;
            r.write_addr = cur_base + cur_count;
            r.write_data = {held_val, nib[3:0]};
            r.progress = (cur_count % 32'(PROGRESS_INTERVAL_DEF)) == 0;
            cur_count = cur_count + 1;
         end else begin
            r.ev = EV_REJECT;
            r.echo_n = ECHO_TWO;
            r.echo_a = held_ch;
            r.echo_b = c;
         end
      end else if (c == CHAR_END || c == CHAR_AT) begin
         r.ev = (c == CHAR_END) ? EV_RUN : EV_ADDR_START;
         if (cur_count != 0) begin
            r.rpt_valid = 1'b1;
            r.rpt_count = cur_count;
            r.rpt_base = cur_base;
         end
         if (c == CHAR_END) begin
            load_done = 1'b1;
         end else begin
            addr_acc = '0;
            cur_mode = MODE_ADDR;
         end
      end else if (!nib[4]) begin
         held_val = nib[3:0];
         held_ch = c;
         cur_mode = MODE_HELD;
      end else if (!(c inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF})) begin
         r.ev = EV_REJECT;
         r.echo_n = ECHO_ONE;
         r.echo_a = c;
      end
      return r;
   endfunction

   function automatic int idle_len(input bit calm);
      int p;
      if (calm) return 0;
      p = $urandom_range(99, 0);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(3, 1);
      if (p < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(1, 0) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] space_char();
      case ($urandom_range(3, 0))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // A code 0 in normal mode would end the load, so it is held back for the end.
   function automatic logic [7:0] keep_loading(input logic [7:0] b);
      if (b == CHAR_END && cur_mode == MODE_NORMAL) return 8'h2a;
      return b;
   endfunction

   function automatic logic [7:0] cut_char();
      logic [7:0] b;
      logic [4:0] nib;
      case ($urandom_range(9, 0))
         0, 1, 2, 3: b = space_char();
         4: b = CHAR_AT;
         5: b = CHAR_END;
         default: begin
            do begin
               b = 8'($urandom);
               nib = nibble_of(b);
            end while (!nib[4]);
         end
      endcase
      return keep_loading(b);
   endfunction

   task automatic send_char(input logic [7:0] c, input bit fixed = 1'b0,
                            input load_event_type fixed_res = '0);
      int             gap;
      load_event_type pred;
      gap = idle_len(tx_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = parse_char(c);
      pending_events.push_back(fixed ? fixed_res : pred);
      chars_sent++;
   endtask

   task automatic send_text_chunk();
      int kind;
      kind = $urandom_range(99, 0);
      if (kind < 55) begin
         // Data line: hex pairs, sometimes split by whitespace.
         repeat ($urandom_range(16, 1)) begin
            send_char(digit_char(4'($urandom)));
            send_char(digit_char(4'($urandom)));
            if ($urandom_range(9, 0) < 3) send_char(space_char());
         end
      end else if (kind < 72) begin
         send_char(CHAR_AT);
         repeat ($urandom_range(9, 0)) send_char(digit_char(4'($urandom)));
         send_char(cut_char());
      end else if (kind < 87) begin
         repeat ($urandom_range(4, 1)) send_char(keep_loading(8'($urandom)));
      end else if (kind < 95) begin
         send_char(digit_char(4'($urandom)));
         send_char(cut_char());
      end else begin
         repeat ($urandom_range(5, 1)) send_char(space_char());
      end
   endtask

   task automatic send_random(input int n);
      int target;
      target = chars_sent + n;
      while (chars_sent < target) send_text_chunk();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   task automatic write_start(input logic [31:0] v);
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      cur_base = v;
      cur_count = '0;
      settings++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result(input load_event_type want, input logic [2:0] u,
                               input logic [127:0] d);
      check_field("event_res", 32'(want.ev), 32'(u));
      check_field("write_addr", want.write_addr, d[31:0]);
      check_field("write_data", 32'(want.write_data), 32'(d[39:32]));
      check_field("progress_mark", 32'(want.progress), 32'(d[40]));
      check_field("echo_count", 32'(want.echo_n), 32'(d[42:41]));
      check_field("echo_first", 32'(want.echo_a), 32'(d[50:43]));
      check_field("echo_second", 32'(want.echo_b), 32'(d[58:51]));
      check_field("report_valid", 32'(want.rpt_valid), 32'(d[59]));
      check_field("report_count", want.rpt_count, d[91:60]);
      check_field("report_base", want.rpt_base, d[123:92]);
      check_field("tdata_pad", 32'd0, 32'(d[127:124]));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         results_seen++;
         if (!$isunknown(rsp_tuser)) ev_seen[rsp_tuser]++;
         if (rsp_tdata[40] === 1'b1) marks_seen++;
         if (pending_events.size() == 0) begin
            $error("result item with no expected result pending");
            mismatches++;
         end else begin
            head = pending_events.pop_front();
            check_result(head, rsp_tuser, rsp_tdata);
         end
      end
   end

   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(rx_calm ? 50 : 8, 1)) @(posedge clock);
            n = idle_len(rx_calm);
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   initial begin
      dir_rows = '{
         '{CHAR_SPACE, 1'b1, '{ev: EV_NOTHING, default: '0}},
         '{CHAR_TAB, 1'b1, '{ev: EV_NOTHING, default: '0}},
         '{CHAR_CR, 1'b1, '{ev: EV_NOTHING, default: '0}},
         '{CHAR_LF, 1'b1, '{ev: EV_NOTHING, default: '0}},
         '{"0", 1'b1, '{ev: EV_NOTHING, default: '0}},
         '{"0", 1'b1, '{ev: EV_WRITE, write_addr: 32'h0001_0000, progress: 1'b1,
                        default: '0}},
         '{"F", 1'b1, '{ev: EV_NOTHING, default: '0}},
         '{"f", 1'b1, '{ev: EV_WRITE, write_addr: 32'h0001_0001, write_data: 8'hff,
                        default: '0}},
         '{"a", 1'b0, '0},
         '{"G", 1'b1, '{ev: EV_REJECT, echo_n: ECHO_TWO, echo_a: "a", echo_b: "G",
                        default: '0}},
         '{8'hff, 1'b1, '{ev: EV_REJECT, echo_n: ECHO_ONE, echo_a: 8'hff, default: '0}},
         '{8'h01, 1'b1, '{ev: EV_REJECT, echo_n: ECHO_ONE, echo_a: 8'h01, default: '0}},
         '{"9", 1'b0, '0},
         '{CHAR_AT, 1'b1, '{ev: EV_REJECT, echo_n: ECHO_TWO, echo_a: "9", echo_b: CHAR_AT,
                            default: '0}},
         '{CHAR_AT, 1'b1, '{ev: EV_ADDR_START, rpt_valid: 1'b1, rpt_count: 32'd2,
                            rpt_base: START_RESET, default: '0}},
         '{"C", 1'b0, '0},
         '{"a", 1'b0, '0},
         '{"f", 1'b0, '0},
         '{"E", 1'b0, '0},
         '{CHAR_END, 1'b1, '{ev: EV_ADDR_SET, default: '0}},
         '{"B", 1'b0, '0},
         '{CHAR_SPACE, 1'b1, '{ev: EV_REJECT, echo_n: ECHO_TWO, echo_a: "B",
                               echo_b: CHAR_SPACE, default: '0}},
         '{"7", 1'b0, '0},
         '{"d", 1'b0, '0},
         '{CHAR_AT, 1'b0, '0},
         '{"x", 1'b0, '0}
      };
      foreach (ev_seen[i]) ev_seen[i] = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      cur_base = START_RESET;
      cur_count = '0;
      addr_acc = '0;
      cur_mode = MODE_NORMAL;
      held_val = '0;
      held_ch = '0;
      load_done = 1'b0;

      foreach (dir_rows[i]) send_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);

      // Top start address, with one long receiver stall while items keep coming.
      drain();
      write_start(32'hFFFF_FFFF);
      hold_rsp = 1'b1;
      send_random(150);

      // Zero start address, back to back on both sides.
      drain();
      write_start(32'h0000_0000);
      tx_calm = 1'b1;
      rx_calm = 1'b1;
      send_random(120);

      drain();
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      write_start(32'($urandom));
      send_random(160);

      // One unbroken run of byte writes from a start address just below the top.
      if (cur_mode != MODE_NORMAL) send_char(CHAR_SPACE);
      drain();
      write_start(32'hFFFF_FF00);
      repeat (150) begin
         send_char(digit_char(4'($urandom)));
         send_char(digit_char(4'($urandom)));
      end
      send_random(20);

      while (!load_done) send_char(CHAR_END);
      repeat (6) send_char(8'($urandom));

      drain();
      repeat (8) @(posedge clock);
      $display("Checked %0d results: %0d byte writes, %0d progress marks, %0d rejects,",
               results_seen, ev_seen[EV_WRITE], marks_seen, ev_seen[EV_REJECT]);
      $display("%0d address records, %0d ignored after end; %0d chars, %0d base settings.",
               ev_seen[EV_ADDR_SET], ev_seen[EV_IGNORED], chars_sent, settings);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/hilp_pkg.sv
rtl/core/hilp_skid.sv
rtl/core/hex_image_loader_parser_unit.sv
bench/tb_top.sv
